// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define TGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that forces another one in the next cycle
`define TGC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);

`endif

// ===== rtl/tgc_pkg.sv =====
package tgc_pkg;

  // contact storage sizing
  localparam int MAX_CONTACTS = 10;
  localparam int CNT_W        = $clog2(MAX_CONTACTS + 1);
  localparam int IDX_W        = $clog2(MAX_CONTACTS);

  // request queue sizing
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // ratio arithmetic widths
  localparam int D2_W   = 34;
  localparam int DIV_W  = D2_W + 24;
  localparam int ROOT_W = DIV_W / 2;
  localparam int REM_W  = ROOT_W + 1;
  localparam int STEP_W = $clog2(DIV_W);

  // register reset values and constants
  localparam logic [11:0] PALM_RADIUS_RST = 12'd640;
  localparam logic [11:0] PALM_GROWTH_RST = 12'd320;
  localparam logic [11:0] DOLLY_THR_RST   = 12'd205;
  localparam logic [9:0]  LOW_PRESSURE    = 10'd51;
  localparam logic [15:0] RATIO_ONE       = 16'd4096;

  typedef enum logic [1:0] {
    CFG_PALM_RADIUS = 2'd0,
    CFG_PALM_GROWTH = 2'd1,
    CFG_DOLLY_THR   = 2'd2,
    CFG_STRICT      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ORBIT = 2'd1,
    KIND_PAN   = 2'd2,
    KIND_DOLLY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_FINGER = 2'd1,
    CMD_PALM   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic        we;
    cfg_idx_e    idx;
    logic [11:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] x;
    logic [15:0] y;
  } contact_t;

  typedef struct packed {
    cmd_e     cmd;
    logic     last;
    contact_t ct;
  } req_t;

endpackage

// ===== rtl/touch_gesture_classifier.sv =====
// Touch gesture classifier: one result per touch frame.
// Input: an item is taken when start is high and busy is low. Contact items
// of one frame are sent in turn, the final one marked by last_in_frame_i;
// operation_i high clears the stored history and gives no result.
// Items are palm-tested on entry and pass through a two-entry request queue
// to the frame engine; busy rises only while that queue is full.
// The engine stores each finger item as it pops it. At a frame end it
// searches the history for each id, checks the frame and gives the
// result, then updates the history. Two-finger frames add a squaring
// pass and, when the prior distance is not zero, a pass through the
// shared divide and square-root unit (58 quotient bits then 29 root
// bits, one per cycle); a result is delayed while the engine is still
// busy with the previous frame.
// Result: valid_o is high for one cycle with the result fields; the
// receiver cannot stall, so every result is taken that cycle.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i write a register at once.
// Reset clears history, frame counts and the queue and loads the default
// register values; no clearing pass is needed.
module touch_gesture_classifier import tgc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [11:0]        cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic               operation_i,
  input  logic               contact_present_i,
  input  logic [15:0]        contact_id_i,
  input  logic [15:0]        pos_x_i,
  input  logic [15:0]        pos_y_i,
  input  logic [11:0]        major_radius_i,
  input  logic [9:0]         pressure_i,
  input  logic               last_in_frame_i,
  output logic               valid_o,
  output logic [1:0]         gesture_kind_o,
  output logic signed [17:0] delta_x_o,
  output logic signed [17:0] delta_y_o,
  output logic [15:0]        dolly_factor_o,
  output logic [3:0]         fingertip_count_o,
  output logic [3:0]         rejected_count_o
);

  cfg_wr_t cfg;
  logic    push, pop, full, empty;
  req_t    push_req, pop_req;

  // configuration write group
  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_e'(cfg_idx_i);
  assign cfg.data = cfg_data_i;

  assign busy = full;

  tgc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .accept_i          (start && !busy),
    .operation_i       (operation_i),
    .contact_present_i (contact_present_i),
    .contact_id_i      (contact_id_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .major_radius_i    (major_radius_i),
    .pressure_i        (pressure_i),
    .last_in_frame_i   (last_in_frame_i),
    .push_o            (push),
    .push_req_o        (push_req)
  );

  tgc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .pop_req_o  (pop_req),
    .full_o     (full),
    .empty_o    (empty)
  );

  tgc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .empty_i           (empty),
    .req_i             (pop_req),
    .pop_o             (pop),
    .valid_o           (valid_o),
    .gesture_kind_o    (gesture_kind_o),
    .delta_x_o         (delta_x_o),
    .delta_y_o         (delta_y_o),
    .dolly_factor_o    (dolly_factor_o),
    .fingertip_count_o (fingertip_count_o),
    .rejected_count_o  (rejected_count_o)
  );

endmodule

// ===== rtl/tgc_front.sv =====
module tgc_front import tgc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_wr_t     cfg_i,
  input  logic        accept_i,
  input  logic        operation_i,
  input  logic        contact_present_i,
  input  logic [15:0] contact_id_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [11:0] major_radius_i,
  input  logic [9:0]  pressure_i,
  input  logic        last_in_frame_i,
  output logic        push_o,
  output req_t        push_req_o
);

  logic [11:0]      palm_radius_q;
  logic [11:0]      palm_growth_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [23:0]      grown;
  logic             is_palm;
  logic             room;

  // palm settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palm_radius_q <= PALM_RADIUS_RST;
      palm_growth_q <= PALM_GROWTH_RST;
    end else if (cfg_i.we) begin
      if (cfg_i.idx == CFG_PALM_RADIUS) palm_radius_q <= cfg_i.data;
      if (cfg_i.idx == CFG_PALM_GROWTH) palm_growth_q <= cfg_i.data;
    end
  end

  // palm test: large radius, or settling contact with low pressure
  assign grown   = 24'(major_radius_i) * 24'(palm_growth_q);
  assign is_palm = (major_radius_i >= palm_radius_q) ||
                   ((grown >= {4'h0, palm_radius_q, 8'h00}) && (pressure_i <= LOW_PRESSURE));
  assign room    = fill_q < CNT_W'(MAX_CONTACTS);

  // classify the request
  always_comb begin
    push_req_o.ct   = '{id: contact_id_i, x: pos_x_i, y: pos_y_i};
    push_req_o.last = last_in_frame_i;
    if (operation_i) begin
      push_req_o.cmd  = CMD_CLEAR;
      push_req_o.last = 1'b0;
    end else if (contact_present_i && room) begin
      push_req_o.cmd = is_palm ? CMD_PALM : CMD_FINGER;
    end else begin
      push_req_o.cmd = CMD_NONE;
    end
  end

  assign push_o = accept_i;

  // contacts taken in the frame being collected
  always_comb begin
    fill_d = fill_q;
    if (accept_i && !operation_i) begin
      if (last_in_frame_i) begin
        fill_d = '0;
      end else if (contact_present_i && room) begin
        fill_d = fill_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

// ===== rtl/tgc_queue.sv =====
module tgc_queue import tgc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_req_i,
  input  logic pop_i,
  output req_t pop_req_o,
  output logic full_o,
  output logic empty_o
);

`include "assert_macros.svh"

  req_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q;
  logic [Q_PTR_W-1:0] rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;

  assign full_o    = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign empty_o   = cnt_q == '0;
  assign pop_req_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

  `TGC_ASSERT(a_no_push_full, !(push_i && full_o), "request pushed into full queue")
  `TGC_ASSERT(a_no_pop_empty, !(pop_i && empty_o), "request popped from empty queue")

endmodule

// ===== rtl/tgc_ratio.sv =====
module tgc_ratio import tgc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [D2_W-1:0] num_i,
  input  logic [D2_W-1:0] den_i,
  output logic            done_o,
  output logic [15:0]     ratio_o
);

`include "assert_macros.svh"

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_DIV  = 3'b010,
    R_SQRT = 3'b100
  } rstate_e;

  rstate_e           state_q;
  logic [STEP_W-1:0] step_q;
  logic [D2_W-1:0]   den_q;
  logic [D2_W-1:0]   acc_q;
  logic [DIV_W-1:0]  quo_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic              done_q;
  logic [D2_W:0]     div_t;
  logic              div_ge;
  logic [REM_W+1:0]  sq_t;
  logic [REM_W+1:0]  trial;
  logic              sq_ge;

  // one quotient bit per step
  assign div_t  = {acc_q, quo_q[DIV_W-1]};
  assign div_ge = div_t >= {1'b0, den_q};

  // one root bit per step
  assign sq_t  = {rem_q, quo_q[DIV_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign sq_ge = sq_t >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        R_IDLE: begin
          if (start_i) begin
            state_q <= R_DIV;
            step_q  <= '0;
          end
        end
        R_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_W - 1)) begin
            state_q <= R_SQRT;
            step_q  <= '0;
          end
        end
        R_SQRT: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(ROOT_W - 1)) begin
            state_q <= R_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      R_IDLE: begin
        if (start_i) begin
          den_q  <= den_i;
          acc_q  <= '0;
          quo_q  <= {num_i, 24'h0};
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      R_DIV: begin
        acc_q <= div_ge ? D2_W'(div_t - {1'b0, den_q}) : D2_W'(div_t);
        quo_q <= {quo_q[DIV_W-2:0], div_ge};
      end
      R_SQRT: begin
        rem_q  <= sq_ge ? REM_W'(sq_t - trial) : REM_W'(sq_t);
        root_q <= {root_q[ROOT_W-2:0], sq_ge};
        quo_q  <= {quo_q[DIV_W-3:0], 2'b00};
      end
      default: ;
    endcase
  end

  // saturate to Q4.12
  assign ratio_o = (|root_q[ROOT_W-1:16]) ? 16'hFFFF : root_q[15:0];
  assign done_o  = done_q;

  `TGC_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "ratio done longer than one cycle")

endmodule

// ===== rtl/tgc_back.sv =====
module tgc_back import tgc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_wr_t            cfg_i,
  input  logic               empty_i,
  input  req_t               req_i,
  output logic               pop_o,
  output logic               valid_o,
  output logic [1:0]         gesture_kind_o,
  output logic signed [17:0] delta_x_o,
  output logic signed [17:0] delta_y_o,
  output logic [15:0]        dolly_factor_o,
  output logic [3:0]         fingertip_count_o,
  output logic [3:0]         rejected_count_o
);

`include "assert_macros.svh"

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b00000001,
    ST_SEARCH = 8'b00000010,
    ST_CHECK  = 8'b00000100,
    ST_SQUARE = 8'b00001000,
    ST_RATIO  = 8'b00010000,
    ST_DECIDE = 8'b00100000,
    ST_OUT    = 8'b01000000,
    ST_COMMIT = 8'b10000000
  } state_e;

  state_e             state_q;
  contact_t           frame_q [MAX_CONTACTS];
  contact_t           prior_q [MAX_CONTACTS];
  logic [CNT_W-1:0]   ff_q, fr_q, pc_q, idx_q, n_q;
  logic               hist_q, strict_q;
  logic [11:0]        thr_q;
  logic               tracked_q, fnd0_q, fnd1_q;
  logic [15:0]        f0x_q, f0y_q, f1x_q, f1y_q;
  logic [15:0]        p0x_q, p0y_q, p1x_q, p1y_q;
  logic [1:0]         sq_q;
  logic [D2_W-1:0]    d2_q, d2p_q;
  logic [15:0]        ratio_q;
  logic               rstart_q;
  kind_e              kind_q;
  logic signed [17:0] dx_q, dy_q;
  logic [15:0]        factor_q;

  contact_t           cur;
  contact_t           pm;
  logic               found, dup, in_range, go_ok;
  logic [IDX_W-1:0]   pidx;
  logic [15:0]        opa, opb, mag;
  logic [31:0]        sqr;
  logic [D2_W-1:0]    d2p_next;
  logic [15:0]        dev;
  logic               rdone;
  logic [15:0]        rratio;
  logic               frame_we, prior_we;

  // current frame entry and id match against the history
  assign cur      = frame_q[idx_q[IDX_W-1:0]];
  assign in_range = idx_q < ff_q;

  always_comb begin
    found = 1'b0;
    dup   = 1'b0;
    pidx  = '0;
    for (int j = MAX_CONTACTS - 1; j >= 0; j--) begin
      if ((CNT_W'(j) < pc_q) && (prior_q[j].id == cur.id)) begin
        found = 1'b1;
        pidx  = IDX_W'(j);
      end
      if ((CNT_W'(j) < n_q) && (prior_q[j].id == cur.id)) begin
        dup = 1'b1;
      end
    end
  end

  assign pm = prior_q[pidx];

  // one squared coordinate difference per cycle
  always_comb begin
    case (sq_q)
      2'd0:    begin opa = f1x_q; opb = f0x_q; end
      2'd1:    begin opa = f1y_q; opb = f0y_q; end
      2'd2:    begin opa = p1x_q; opb = p0x_q; end
      default: begin opa = p1y_q; opb = p0y_q; end
    endcase
  end

  assign mag      = (opa >= opb) ? opa - opb : opb - opa;
  assign sqr      = 32'(mag) * 32'(mag);
  assign d2p_next = d2p_q + D2_W'(sqr);

  assign go_ok = hist_q && !(strict_q && !(tracked_q && (pc_q == ff_q)));
  assign dev   = (ratio_q >= RATIO_ONE) ? ratio_q - RATIO_ONE : RATIO_ONE - ratio_q;

  tgc_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rstart_q),
    .num_i   (d2_q),
    .den_i   (d2p_q),
    .done_o  (rdone),
    .ratio_o (rratio)
  );

  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign frame_we = pop_o && (req_i.cmd == CMD_FINGER);
  assign prior_we = (state_q == ST_COMMIT) && in_range && !dup;

  // contact tables
  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_q[ff_q[IDX_W-1:0]] <= req_i.ct;
    end
    if (prior_we) begin
      prior_q[n_q[IDX_W-1:0]] <= cur;
    end
  end

  // tracking settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= DOLLY_THR_RST;
      strict_q <= 1'b1;
    end else if (cfg_i.we) begin
      if (cfg_i.idx == CFG_DOLLY_THR) thr_q <= cfg_i.data;
      if (cfg_i.idx == CFG_STRICT) strict_q <= cfg_i.data[0];
    end
  end

  // frame sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ff_q     <= '0;
      fr_q     <= '0;
      pc_q     <= '0;
      hist_q   <= 1'b0;
      idx_q    <= '0;
      n_q      <= '0;
      rstart_q <= 1'b0;
    end else begin
      rstart_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            case (req_i.cmd)
              CMD_CLEAR: begin
                pc_q   <= '0;
                hist_q <= 1'b0;
              end
              CMD_FINGER: ff_q <= ff_q + CNT_W'(1);
              CMD_PALM:   fr_q <= fr_q + CNT_W'(1);
              default: ;
            endcase
            if (req_i.last) begin
              state_q <= ST_SEARCH;
              idx_q   <= '0;
            end
          end
        end
        ST_SEARCH: begin
          if (in_range) begin
            idx_q <= idx_q + CNT_W'(1);
          end else begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (go_ok && (ff_q == CNT_W'(2)) && fnd0_q && fnd1_q) begin
            state_q <= ST_SQUARE;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_SQUARE: begin
          if (sq_q == 2'd3) begin
            if (d2p_next == '0) begin
              state_q <= ST_DECIDE;
            end else begin
              state_q  <= ST_RATIO;
              rstart_q <= 1'b1;
            end
          end
        end
        ST_RATIO: begin
          if (rdone) state_q <= ST_DECIDE;
        end
        ST_DECIDE: state_q <= ST_OUT;
        ST_OUT: begin
          state_q <= ST_COMMIT;
          idx_q   <= '0;
          n_q     <= '0;
        end
        ST_COMMIT: begin
          if (in_range) begin
            idx_q <= idx_q + CNT_W'(1);
            if (!dup) n_q <= n_q + CNT_W'(1);
          end else begin
            pc_q    <= n_q;
            hist_q  <= 1'b1;
            ff_q    <= '0;
            fr_q    <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // gesture datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        tracked_q <= 1'b1;
        fnd0_q    <= 1'b0;
        fnd1_q    <= 1'b0;
      end
      ST_SEARCH: begin
        if (in_range) begin
          if (!found) tracked_q <= 1'b0;
          if (idx_q == CNT_W'(0)) begin
            fnd0_q <= found;
            f0x_q  <= cur.x;
            f0y_q  <= cur.y;
            p0x_q  <= pm.x;
            p0y_q  <= pm.y;
          end
          if (idx_q == CNT_W'(1)) begin
            fnd1_q <= found;
            f1x_q  <= cur.x;
            f1y_q  <= cur.y;
            p1x_q  <= pm.x;
            p1y_q  <= pm.y;
          end
        end
      end
      ST_CHECK: begin
        kind_q   <= KIND_NONE;
        dx_q     <= '0;
        dy_q     <= '0;
        factor_q <= RATIO_ONE;
        ratio_q  <= RATIO_ONE;
        sq_q     <= '0;
        d2_q     <= '0;
        d2p_q    <= '0;
        if (go_ok && (ff_q == CNT_W'(1)) && fnd0_q) begin
          kind_q <= KIND_ORBIT;
          dx_q   <= {17'({1'b0, f0x_q} - {1'b0, p0x_q}), 1'b0};
          dy_q   <= {17'({1'b0, f0y_q} - {1'b0, p0y_q}), 1'b0};
        end
      end
      ST_SQUARE: begin
        sq_q <= sq_q + 2'd1;
        if (sq_q[1]) begin
          d2p_q <= d2p_next;
        end else begin
          d2_q <= d2_q + D2_W'(sqr);
        end
      end
      ST_RATIO: begin
        if (rdone) ratio_q <= rratio;
      end
      ST_DECIDE: begin
        if (dev > {4'h0, thr_q}) begin
          kind_q   <= KIND_DOLLY;
          factor_q <= ratio_q;
        end else begin
          kind_q <= KIND_PAN;
          dx_q   <= 18'({1'b0, f0x_q} + {1'b0, f1x_q}) - 18'({1'b0, p0x_q} + {1'b0, p1x_q});
          dy_q   <= 18'({1'b0, f0y_q} + {1'b0, f1y_q}) - 18'({1'b0, p0y_q} + {1'b0, p1y_q});
        end
      end
      default: ;
    endcase
  end

  // result ports
  assign valid_o           = state_q == ST_OUT;
  assign gesture_kind_o    = kind_q;
  assign delta_x_o         = dx_q;
  assign delta_y_o         = dy_q;
  assign dolly_factor_o    = factor_q;
  assign fingertip_count_o = 4'(ff_q);
  assign rejected_count_o  = 4'(fr_q);

  `TGC_ASSERT_NEXT(a_valid_then_commit, valid_o, state_q == ST_COMMIT, "no commit after result")
  `TGC_ASSERT(a_frame_bound, ({1'b0, ff_q} + {1'b0, fr_q}) <= (CNT_W+1)'(MAX_CONTACTS), "frame overfull")

endmodule

// ===== tb/tb_touch_gesture_classifier.sv =====
module tb_touch_gesture_classifier;
  import tgc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 200;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [11:0]        cfg_data_i = '0;
  logic               start = 1'b0;
  logic               busy;
  logic               operation_i = 1'b0;
  logic               contact_present_i = 1'b0;
  logic [15:0]        contact_id_i = '0;
  logic [15:0]        pos_x_i = '0;
  logic [15:0]        pos_y_i = '0;
  logic [11:0]        major_radius_i = '0;
  logic [9:0]         pressure_i = '0;
  logic               last_in_frame_i = 1'b0;
  logic               valid_o;
  logic [1:0]         gesture_kind_o;
  logic signed [17:0] delta_x_o;
  logic signed [17:0] delta_y_o;
  logic [15:0]        dolly_factor_o;
  logic [3:0]         fingertip_count_o;
  logic [3:0]         rejected_count_o;

  typedef struct packed {
    kind_e              kind;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic [15:0]        factor;
    logic [3:0]         fingers;
    logic [3:0]         rejected;
  } gesture_t;

  typedef struct {
    logic        op_clear;
    logic        present;
    logic [15:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic [11:0] radius;
    logic [9:0]  press;
    logic        last;
  } touch_item_t;

  // predictor state
  logic [11:0] m_palm_radius, m_palm_growth, m_dolly_thr;
  logic        m_strict;
  contact_t    m_prior [MAX_CONTACTS];
  int          m_prior_cnt;
  logic        m_history;
  contact_t    m_frame [MAX_CONTACTS];
  int          m_fingers, m_rejected;

  gesture_t gesture_q[$];
  int  fail_cnt = 0;
  int  idle_cycles = 0;
  bit  idle_on = 1'b1;

  always #5 clk_i = ~clk_i;

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      gesture_t exp_g;
      idle_cycles <= 0;
      if (gesture_q.size() == 0) begin
        $error("unexpected gesture result");
        fail_cnt++;
      end else begin
        exp_g = gesture_q.pop_front();
        if (gesture_kind_o !== exp_g.kind) begin
          $error("gesture_kind exp %0d got %0d", exp_g.kind, gesture_kind_o);
          fail_cnt++;
        end
        if (delta_x_o !== exp_g.dx) begin
          $error("delta_x exp %0d got %0d", exp_g.dx, delta_x_o);
          fail_cnt++;
        end
        if (delta_y_o !== exp_g.dy) begin
          $error("delta_y exp %0d got %0d", exp_g.dy, delta_y_o);
          fail_cnt++;
        end
        if (dolly_factor_o !== exp_g.factor) begin
          $error("dolly_factor exp %0d got %0d", exp_g.factor, dolly_factor_o);
          fail_cnt++;
        end
        if (fingertip_count_o !== exp_g.fingers) begin
          $error("fingertip_count exp %0d got %0d", exp_g.fingers, fingertip_count_o);
          fail_cnt++;
        end
        if (rejected_count_o !== exp_g.rejected) begin
          $error("rejected_count exp %0d got %0d", exp_g.rejected, rejected_count_o);
          fail_cnt++;
        end
      end
    end else if (rst_ni && !(start && !busy)) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      idle_cycles <= 0;
    end
  end

  // watchdog on cycles with no result and nothing accepted
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  touch_gesture_classifier i_dut (.*);

  function automatic logic palm_test(logic [11:0] r, logic [9:0] p);
    logic [23:0] prod;
    logic [23:0] lim;
    prod = 24'(r) * 24'(m_palm_growth);
    lim  = {4'd0, m_palm_radius, 8'd0};
    return (r >= m_palm_radius) || (prod >= lim && p <= LOW_PRESSURE);
  endfunction

  function automatic int prior_slot(logic [15:0] id);
    for (int i = 0; i < m_prior_cnt; i++)
      if (m_prior[i].id == id) return i;
    return -1;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] sq_dist(contact_t a, contact_t b);
    longint ddx, ddy;
    ddx = longint'(b.x) - longint'(a.x);
    ddy = longint'(b.y) - longint'(a.y);
    return ddx * ddx + ddy * ddy;
  endfunction

  // classify one item; queues the expected gesture at frame end
  function automatic void predict_gesture(touch_item_t it);
    gesture_t g;
    longint   ddx, ddy;
    logic     tracked;
    int       p0, p1, n;
    logic [63:0] d2, d2p, ratio, dev;
    logic     dup;
    if (it.op_clear) begin
      m_prior_cnt = 0;
      m_history = 1'b0;
      return;
    end
    if (it.present && m_fingers + m_rejected < MAX_CONTACTS) begin
      if (palm_test(it.radius, it.press)) m_rejected++;
      else begin
        m_frame[m_fingers] = '{id: it.id, x: it.x, y: it.y};
        m_fingers++;
      end
    end
    if (!it.last) return;
    g.kind = KIND_NONE;
    ddx = 0;
    ddy = 0;
    g.factor = RATIO_ONE;
    if (m_history) begin
      tracked = (m_prior_cnt == m_fingers);
      for (int i = 0; i < m_fingers; i++)
        if (prior_slot(m_frame[i].id) < 0) tracked = 1'b0;
      if (m_strict && !tracked) begin
      end else if (m_fingers == 1) begin
        p0 = prior_slot(m_frame[0].id);
        if (p0 >= 0) begin
          g.kind = KIND_ORBIT;
          ddx = 2 * (longint'(m_frame[0].x) - longint'(m_prior[p0].x));
          ddy = 2 * (longint'(m_frame[0].y) - longint'(m_prior[p0].y));
        end
      end else if (m_fingers == 2) begin
        p0 = prior_slot(m_frame[0].id);
        p1 = prior_slot(m_frame[1].id);
        if (p0 >= 0 && p1 >= 0) begin
          d2p = sq_dist(m_prior[p0], m_prior[p1]);
          d2 = sq_dist(m_frame[0], m_frame[1]);
          ratio = 64'(RATIO_ONE);
          if (d2p != 0) begin
            ratio = int_sqrt((d2 << 24) / d2p);
            if (ratio > 65535) ratio = 64'd65535;
          end
          dev = (ratio >= 64'(RATIO_ONE)) ? ratio - 64'(RATIO_ONE) : 64'(RATIO_ONE) - ratio;
          if (dev > 64'(m_dolly_thr)) begin
            g.kind = KIND_DOLLY;
            g.factor = ratio[15:0];
          end else begin
            g.kind = KIND_PAN;
            ddx = (longint'(m_frame[0].x) + longint'(m_frame[1].x))
                - (longint'(m_prior[p0].x) + longint'(m_prior[p1].x));
            ddy = (longint'(m_frame[0].y) + longint'(m_frame[1].y))
                - (longint'(m_prior[p0].y) + longint'(m_prior[p1].y));
          end
        end
      end
    end
    g.dx = ddx[17:0];
    g.dy = ddy[17:0];
    g.fingers = m_fingers[3:0];
    g.rejected = m_rejected[3:0];
    gesture_q = {gesture_q, g};
    // history keeps the first position of each id
    n = 0;
    for (int i = 0; i < m_fingers; i++) begin
      dup = 1'b0;
      for (int j = 0; j < n; j++)
        if (m_prior[j].id == m_frame[i].id) dup = 1'b1;
      if (!dup) begin
        m_prior[n] = m_frame[i];
        n++;
      end
    end
    m_prior_cnt = n;
    m_history = 1'b1;
    m_fingers = 0;
    m_rejected = 0;
  endfunction

  // send one request, with an optional random gap before it
  task automatic send_request(touch_item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    operation_i <= it.op_clear;
    contact_present_i <= it.present;
    contact_id_i <= it.id;
    pos_x_i <= it.x;
    pos_y_i <= it.y;
    major_radius_i <= it.radius;
    pressure_i <= it.press;
    last_in_frame_i <= it.last;
    do @(posedge clk_i); while (busy);
    predict_gesture(it);
    @(negedge clk_i);
  endtask

  task automatic send_contact(logic [15:0] id, logic [15:0] x, logic [15:0] y,
                              logic [11:0] r, logic [9:0] p, logic last);
    touch_item_t it;
    it = '{1'b0, 1'b1, id, x, y, r, p, last};
    send_request(it);
  endtask

  task automatic send_empty_end();
    touch_item_t it;
    it = '{1'b0, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 12'($urandom),
           10'($urandom), 1'b1};
    send_request(it);
  endtask

  task automatic send_clear();
    touch_item_t it;
    it = '{1'b1, 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           12'($urandom), 10'($urandom), 1'($urandom)};
    send_request(it);
  endtask

  // wait until idle, then write one register
  task automatic write_reg(cfg_idx_e idx, logic [11:0] val);
    start <= 1'b0;
    while (gesture_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PALM_RADIUS: m_palm_radius = val;
      CFG_PALM_GROWTH: m_palm_growth = val;
      CFG_DOLLY_THR:   m_dolly_thr = val;
      default:         m_strict = val[0];
    endcase
  endtask

  task automatic test_directed();
    // first frame, then orbit with extreme motion
    send_contact(16'h0000, 16'h0000, 16'hFFFF, 12'd0, 10'd1023, 1'b1);
    send_contact(16'h0000, 16'hFFFF, 16'h0000, 12'd10, 10'd0, 1'b1);
    // two fingers: first frame, pan, dolly
    send_contact(16'hFFFF, 16'd100, 16'd100, 12'd5, 10'd500, 1'b0);
    send_contact(16'h1234, 16'd200, 16'd100, 12'd5, 10'd500, 1'b1);
    send_contact(16'hFFFF, 16'd110, 16'd105, 12'd5, 10'd500, 1'b0);
    send_contact(16'h1234, 16'd210, 16'd105, 12'd5, 10'd500, 1'b1);
    send_contact(16'hFFFF, 16'd0, 16'd0, 12'd5, 10'd500, 1'b0);
    send_contact(16'h1234, 16'hFFFF, 16'hFFFF, 12'd5, 10'd500, 1'b1);
    // zero prior distance, then palms by size and by settling
    send_contact(16'd7, 16'd50, 16'd50, 12'd1, 10'd100, 1'b0);
    send_contact(16'd8, 16'd50, 16'd50, 12'd1, 10'd100, 1'b1);
    send_contact(16'd7, 16'd90, 16'd50, 12'd1, 10'd100, 1'b0);
    send_contact(16'd8, 16'd50, 16'd50, 12'd4095, 10'd1023, 1'b0);
    send_contact(16'd9, 16'd50, 16'd50, 12'd600, 10'd51, 1'b0);
    send_contact(16'd8, 16'd70, 16'd50, 12'd1, 10'd100, 1'b1);
    // empty frame, clear mid-frame, untracked finger, duplicate ids
    send_empty_end();
    send_contact(16'd3, 16'd1, 16'd1, 12'd1, 10'd0, 1'b0);
    send_clear();
    send_contact(16'd3, 16'd2, 16'd2, 12'd1, 10'd0, 1'b1);
    send_contact(16'd4, 16'd2, 16'd2, 12'd1, 10'd0, 1'b1);
    send_contact(16'd5, 16'd9, 16'd9, 12'd1, 10'd0, 1'b0);
    send_contact(16'd5, 16'd1, 16'd1, 12'd1, 10'd0, 1'b1);
    // overflow beyond the contact limit
    for (int i = 0; i < 12; i++)
      send_contact(16'(i), 16'(i * 3), 16'(i * 5), (i % 2) ? 12'd4000 : 12'd3, 10'd900,
                   i == 11);
  endtask

  // random frames: mostly tracked gestures, some noise
  task automatic test_random_frames(int frames);
    logic [15:0] ids [2];
    logic [15:0] px [2], py [2];
    int nf, style;
    for (int f = 0; f < frames; f++) begin
      style = $urandom_range(0, 9);
      if (f % 8 == 0 || style == 0) begin
        ids[0] = 16'($urandom);
        ids[1] = 16'($urandom);
        for (int k = 0; k < 2; k++) begin
          px[k] = 16'($urandom);
          py[k] = 16'($urandom);
        end
      end
      for (int k = 0; k < 2; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          px[k] = 16'($urandom);
          py[k] = 16'($urandom);
        end else begin
          px[k] = 16'(px[k] + $urandom_range(0, 60) - 30);
          py[k] = 16'(py[k] + $urandom_range(0, 60) - 30);
        end
      end
      if (style <= 2) nf = 1;
      else if (style <= 7) nf = 2;
      else nf = $urandom_range(0, 11);
      if ($urandom_range(0, 40) == 0) send_clear();
      if (nf <= 2) begin
        for (int k = 0; k < nf; k++)
          send_contact($urandom_range(0, 9) == 0 ? 16'($urandom) : ids[k], px[k], py[k],
                       12'($urandom_range(0, 700)), 10'($urandom), (k == nf - 1) &&
                       ($urandom_range(0, 5) == 0));
        if (nf == 0 || $urandom_range(0, 1) == 0) send_empty_end();
        else send_contact(16'($urandom), 16'($urandom), 16'($urandom), 12'd4095,
                          10'($urandom), 1'b1);
      end else begin
        for (int k = 0; k < nf; k++)
          send_contact(16'($urandom_range(0, 15)), 16'($urandom), 16'($urandom),
                       12'($urandom), 10'($urandom), k == nf - 1);
      end
    end
  endtask

  initial begin
    m_palm_radius = PALM_RADIUS_RST;
    m_palm_growth = PALM_GROWTH_RST;
    m_dolly_thr = DOLLY_THR_RST;
    m_strict = 1'b1;
    m_prior_cnt = 0;
    m_history = 1'b0;
    m_fingers = 0;
    m_rejected = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    write_reg(CFG_STRICT, 12'd0);
    test_directed();
    write_reg(CFG_PALM_RADIUS, 12'd4095);
    write_reg(CFG_PALM_GROWTH, 12'd4095);
    write_reg(CFG_DOLLY_THR, 12'd0);
    test_random_frames(120);
    write_reg(CFG_PALM_RADIUS, 12'd0);
    write_reg(CFG_PALM_GROWTH, 12'd0);
    write_reg(CFG_DOLLY_THR, 12'd4095);
    test_random_frames(40);
    write_reg(CFG_PALM_RADIUS, 12'd500);
    write_reg(CFG_PALM_GROWTH, 12'd400);
    write_reg(CFG_DOLLY_THR, 12'd205);
    write_reg(CFG_STRICT, 12'd1);
    test_random_frames(150);
    idle_on = 1'b0;
    test_random_frames(80);

    start <= 1'b0;
    while (gesture_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
